[sv/sql_string_literal_unescape_defines.svh]
// Assertion macros for the SQL string literal decoder.
`ifndef SQL_STRING_LITERAL_UNESCAPE_DEFINES_SVH
`define SQL_STRING_LITERAL_UNESCAPE_DEFINES_SVH

`ifndef SYNTHESIS
// implication checked at every rising clock edge outside reset
`define SSLU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// condition that must never hold outside reset
`define SSLU_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);
`else
`define SSLU_ASSERT_IMP(label, ante, cons, msg)
`define SSLU_ASSERT_NEVER(label, cond, msg)
`endif

`endif

[sv/sslu_pkg.sv]
// Types, constants and escape table shared by the SQL literal decoder.
package sslu_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_BANG      = 8'h21;

  typedef enum logic [2:0] {
    PH_OPEN  = 3'd0,
    PH_BODY  = 3'd1,
    PH_DELIM = 3'd2,
    PH_ESC   = 3'd3,
    PH_ERROR = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_OK   = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  // one queue entry: the results caused by one input byte
  typedef struct packed {
    logic [1:0] nbytes;    // decoded bytes, 0..2
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       stat;      // status result follows the bytes
    kind_t      stat_kind;
  } job_t;

  typedef struct packed {
    logic [1:0] nbytes;
    logic [7:0] byte0;
    logic [7:0] byte1;
  } esc_t;

  // backslash escape decode
  function automatic esc_t esc_map(input logic [7:0] c);
    esc_t r;
    r.nbytes = 2'd1;
    r.byte0  = c;
    r.byte1  = 8'h00;
    case (c)
      8'h6E: r.byte0 = 8'h0A;  // n
      8'h72: r.byte0 = 8'h0D;  // r
      8'h66: r.byte0 = 8'h0C;  // f
      8'h76: r.byte0 = 8'h0B;  // v
      8'h62: r.byte0 = 8'h08;  // b
      8'h65: r.byte0 = 8'h1B;  // e
      8'h61: r.byte0 = 8'h07;  // a
      8'h74: r.byte0 = 8'h09;  // t
      8'h25, 8'h5F: begin      // % and _ get a bang in front
        r.nbytes = 2'd2;
        r.byte0  = CH_BANG;
        r.byte1  = c;
      end
      default: r.byte0 = c;
    endcase
    return r;
  endfunction

endpackage

[sv/sql_string_literal_unescape.sv]
// Top level of the streaming SQL string literal decoder.
//
// Decodes quoted SQL string literals fed one raw byte per request. The first
// byte of a literal is its delimiter; a doubled delimiter gives one delimiter
// byte, a backslash escape maps n r f v b e a t to control codes, % and _ to
// the pairs "!%" and "!_", and passes anything else through. The byte flagged
// end_of_literal also yields one status result (ok or malformed), always the
// last of its run; after it the decoder expects a new opening delimiter.
// Rate: one input byte per cycle is accepted while the job queue has room,
// and one result per cycle leaves through the output register while out_ready
// is high. A byte that gives no result (opening delimiter, backslash, closing
// delimiter without end flag, bytes after an error) uses no queue slot; a byte
// giving k results sends them one by one (k is at most 3: an escaped % or _
// that is also the last byte). Sustained throughput is thus set by the single
// output register; the input stalls only when QueueDepth jobs are waiting. An
// accepted byte's job is written into the queue, and its first result is then
// loaded into the output register.
module sql_string_literal_unescape
  import sslu_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
)
(
  input  logic       clk,
  input  logic       rst,
  // input request channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_in,
  input  logic       end_of_literal,
  // result request channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] char_out,
  output logic       last_of_run
);

  logic accept;
  logic push, full, pop, empty;
  job_t job, head;

  // input is taken whenever the queue can hold one more job
  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  // front end: tracks the literal phase and classifies each byte
  sslu_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .char_in        (char_in),
    .end_of_literal (end_of_literal),
    .push           (push),
    .job            (job)
  );

  // decouples byte intake from result delivery
  sslu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (job),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  // back end: one result per cycle into the output register, stalled by out_ready
  sslu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .char_out    (char_out),
    .last_of_run (last_of_run)
  );

endmodule

[sv/sslu_front.sv]
// Front end: literal phase tracking and per-byte classification into jobs.
module sslu_front
  import sslu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] char_in,
  input  logic       end_of_literal,
  output logic       push,
  output job_t       job
);

  phase_t     phase, phase_next;
  logic [7:0] delimiter, delimiter_next;
  logic       bad_at_end;
  esc_t       esc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_OPEN;
      delimiter <= 8'h00;
    end else if (accept) begin
      phase     <= phase_next;
      delimiter <= delimiter_next;
    end
  end

  always_comb begin
    phase_next     = phase;
    delimiter_next = delimiter;
    bad_at_end     = 1'b1;
    esc            = esc_map(char_in);
    job.nbytes     = 2'd0;
    job.byte0      = char_in;
    job.byte1      = 8'h00;
    job.stat       = 1'b0;
    job.stat_kind  = KIND_BAD;
    case (phase)
      PH_OPEN: begin
        delimiter_next = char_in;
        phase_next     = PH_BODY;
      end
      PH_BODY: begin
        if (char_in == delimiter) begin
          bad_at_end = !end_of_literal;
          phase_next = PH_DELIM;
        end else if (char_in == CH_BACKSLASH) begin
          phase_next = PH_ESC;
        end else begin
          job.nbytes = 2'd1;
        end
      end
      PH_DELIM: begin
        if (char_in == delimiter) begin
          job.nbytes = 2'd1;
          phase_next = PH_BODY;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_ESC: begin
        job.nbytes = esc.nbytes;
        job.byte0  = esc.byte0;
        job.byte1  = esc.byte1;
        phase_next = PH_BODY;
      end
      default: phase_next = PH_ERROR;
    endcase
    if (end_of_literal) begin
      job.stat      = 1'b1;
      job.stat_kind = bad_at_end ? KIND_BAD : KIND_OK;
      phase_next    = PH_OPEN;
    end
    push = accept && (job.nbytes != 2'd0 || job.stat);
  end

endmodule

[sv/sslu_queue.sv]
// Small job queue between front end and output sequencer.
`include "sql_string_literal_unescape_defines.svh"
module sslu_queue
  import sslu_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
)
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  job_t            entries [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full  = (count == CntFull);
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `SSLU_ASSERT_NEVER(a_no_push_full, push && full && !pop, "queue overflow")
  `SSLU_ASSERT_NEVER(a_no_pop_empty, pop && empty, "queue underflow")
  `SSLU_ASSERT_IMP(a_count_range, 1'b1, count <= CntFull, "queue count out of range")

endmodule

[sv/sslu_back.sv]
// Output sequencer: expands each job into results, one per cycle unless out_ready stalls it.
`include "sql_string_literal_unescape_defines.svh"
module sslu_back
  import sslu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  job_t       head,
  input  logic       empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] char_out,
  output logic       last_of_run
);

  logic [1:0] idx;
  logic       load, take, is_last;
  logic [1:0] total;
  kind_t      kind_sel;
  logic [7:0] char_sel;
  kind_t      kind_r;

  always_comb begin
    load    = !out_valid || out_ready;
    take    = load && !empty;
    total   = head.nbytes + {1'b0, head.stat};
    is_last = (idx == total - 2'd1);
    if (idx < head.nbytes) begin
      kind_sel = KIND_BYTE;
      char_sel = (idx == 2'd0) ? head.byte0 : head.byte1;
    end else begin
      kind_sel = head.stat_kind;
      char_sel = 8'h00;
    end
    pop = take && is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= !empty;
      end
      if (take) begin
        idx <= is_last ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind_r      <= kind_sel;
      char_out    <= char_sel;
      last_of_run <= is_last;
    end
  end

  assign kind = kind_r;

  `SSLU_ASSERT_IMP(a_status_ends_run, out_valid && kind_r != KIND_BYTE, last_of_run, "status not last")
  `SSLU_ASSERT_IMP(a_status_zero_char, out_valid && kind_r != KIND_BYTE, char_out == 8'h00, "status byte")
  `SSLU_ASSERT_NEVER(a_idx_range, !empty && idx >= total && total != 2'd0, "index past job")

endmodule

[tb/sslu_result_checker.sv]
// Result checker for the SQL string literal decoder: predicts and compares every result.
module sslu_result_checker
  import sslu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] char_in,
  input  logic       end_of_literal,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] kind,
  input  logic [7:0] char_out,
  input  logic       last_of_run,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic       last;
  } decoded_t;

  decoded_t   decoded_q[$];
  phase_t     lit_phase;
  logic [7:0] lit_delim;

  // escaped byte -> one or two output bytes
  function automatic int escape_bytes(input logic [7:0] c, output logic [7:0] b0,
                                      output logic [7:0] b1);
    b0 = c;
    b1 = c;
    case (c)
      8'h6E: b0 = 8'h0A;
      8'h72: b0 = 8'h0D;
      8'h66: b0 = 8'h0C;
      8'h76: b0 = 8'h0B;
      8'h62: b0 = 8'h08;
      8'h65: b0 = 8'h1B;
      8'h61: b0 = 8'h07;
      8'h74: b0 = 8'h09;
      8'h25, 8'h5F: begin
        b0 = CH_BANG;
        return 2;
      end
      default: ;
    endcase
    return 1;
  endfunction

  task automatic decode_byte(input logic [7:0] c, input logic eol);
    decoded_t   run[$];
    logic [7:0] b0;
    logic [7:0] b1;
    int         n;
    logic       closed_ok;
    closed_ok = 1'b0;
    case (lit_phase)
      PH_OPEN: begin
        lit_delim = c;
        lit_phase = PH_BODY;
      end
      PH_BODY: begin
        if (c == lit_delim) begin
          closed_ok = eol;
          lit_phase = PH_DELIM;
        end else if (c == CH_BACKSLASH) begin
          lit_phase = PH_ESC;
        end else begin
          run.push_back('{KIND_BYTE, c, 1'b0});
        end
      end
      PH_DELIM: begin
        if (c == lit_delim) begin
          run.push_back('{KIND_BYTE, c, 1'b0});
          lit_phase = PH_BODY;
        end else begin
          lit_phase = PH_ERROR;
        end
      end
      PH_ESC: begin
        n = escape_bytes(c, b0, b1);
        run.push_back('{KIND_BYTE, b0, 1'b0});
        if (n == 2) run.push_back('{KIND_BYTE, b1, 1'b0});
        lit_phase = PH_BODY;
      end
      default: lit_phase = PH_ERROR;
    endcase
    if (eol) begin
      if (closed_ok) run.push_back('{KIND_OK, 8'h00, 1'b0});
      else run.push_back('{KIND_BAD, 8'h00, 1'b0});
      lit_phase = PH_OPEN;
    end
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[i]) decoded_q.push_back(run[i]);
  endtask

  // results leave first: one accepted at this edge can only stem from earlier requests
  always @(posedge clk) begin : watch
    decoded_t want;
    if (rst) begin
      decoded_q.delete();
      lit_phase = PH_OPEN;
      lit_delim = 8'h00;
      fail_count = 0;
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result kind=%0d char=%02h last=%0b",
                     $realtime, kind, char_out, last_of_run);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          if (kind !== want.kind || char_out !== want.ch || last_of_run !== want.last) begin
            if (fail_count < 10)
              $display("%0t: mismatch exp kind=%0d char=%02h last=%0b, %s",
                       $realtime, want.kind, want.ch, want.last,
                       $sformatf("got kind=%0d char=%02h last=%0b",
                                 kind, char_out, last_of_run));
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) decode_byte(char_in, end_of_literal);
      pending <= decoded_q.size();
    end
  end

endmodule

[tb/tb_top.sv]
// Stimulus and verdict for the SQL string literal decoder testbench.
module tb_top
  import sslu_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int TARGET_BYTES = 300;   // directed part plus about 280 random
  localparam int HOLD_AT      = 40;    // result count at which the long stall starts
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 16;

  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic [7:0] char_in = 8'h00;
  logic       end_of_literal = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [1:0] kind;
  logic [7:0] char_out;
  logic       last_of_run;

  int fail_count;
  int pending;
  int cycle_cnt = 0;
  int sent_count = 0;
  int taken_count = 0;

  logic [7:0] lit_bytes[$];   // literal being built, end flag goes on its last byte

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sql_string_literal_unescape u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .char_in        (char_in),
    .end_of_literal (end_of_literal),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .char_out       (char_out),
    .last_of_run    (last_of_run)
  );

  sslu_result_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .char_in        (char_in),
    .end_of_literal (end_of_literal),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .char_out       (char_out),
    .last_of_run    (last_of_run),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // watchdog: a hang anywhere ends the run as a failure
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("sql_string_literal_unescape test failed");
      $finish;
    end
  end

  // One request on the input side. Valid stays up across back-to-back requests;
  // it only drops when a gap is drawn. Every fourth block of 30 requests runs
  // with no gaps at all.
  task automatic send_byte(input logic [7:0] c, input logic eol);
    int gap;
    gap = (((sent_count / 30) % 4) == 2) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    char_in        <= c;
    end_of_literal <= eol;
    do begin
      @(posedge clk);
    end while (!in_ready);
    sent_count++;
  endtask

  task automatic send_literal();
    foreach (lit_bytes[i]) send_byte(lit_bytes[i], i == lit_bytes.size() - 1);
  endtask

  // body byte that is neither the delimiter nor a backslash
  function automatic logic [7:0] plain_byte(input logic [7:0] delim);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == delim || c == CH_BACKSLASH);
    return c;
  endfunction

  function automatic logic [7:0] escape_char();
    case ($urandom_range(0, 11))
      0: return 8'h6E;       // n
      1: return 8'h72;       // r
      2: return 8'h66;       // f
      3: return 8'h76;       // v
      4: return 8'h62;       // b
      5: return 8'h65;       // e
      6: return 8'h61;       // a
      7: return 8'h74;       // t
      8: return 8'h25;       // %
      9: return 8'h5F;       // _
      default: return 8'($urandom_range(0, 255));  // passes through, delimiter too
    endcase
  endfunction

  // Random literal: mostly well-formed with random content, the rest mostly broken in
  // ways the decoder flags as malformed (random tail bytes may still close it well).
  task automatic build_literal();
    logic [7:0] delim;
    int         ntok;
    int         sel;
    lit_bytes.delete();
    sel = $urandom_range(0, 9);
    if (sel < 4) delim = CH_QUOTE;
    else if (sel < 6) delim = CH_DQUOTE;
    else if (sel == 6) delim = CH_BACKSLASH;
    else delim = 8'($urandom_range(0, 255));
    lit_bytes.push_back(delim);
    ntok = $urandom_range(0, 8);
    repeat (ntok) begin
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
        lit_bytes.push_back(plain_byte(delim));
      end else if (sel < 7) begin
        // doubled delimiter
        lit_bytes.push_back(delim);
        lit_bytes.push_back(delim);
      end else begin
        lit_bytes.push_back(CH_BACKSLASH);
        lit_bytes.push_back(escape_char());
      end
    end
    if ($urandom_range(0, 4) != 0) begin
      lit_bytes.push_back(delim);
    end else begin
      case ($urandom_range(0, 3))
        0: lit_bytes.push_back(plain_byte(delim));       // never closed
        1: lit_bytes.push_back(CH_BACKSLASH);            // trailing backslash
        2: begin
          // delimiter followed by junk; the rest is dropped
          lit_bytes.push_back(delim);
          repeat ($urandom_range(1, 3)) lit_bytes.push_back(8'($urandom_range(0, 255)));
        end
        default: repeat ($urandom_range(0, 5)) lit_bytes.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // Result side: random stalls per result, bursts with none, and one long
  // hold-off so the job queue fills and the input backs up.
  initial begin : drain
    int stall;
    do begin
      @(posedge clk);
    end while (rst);
    forever begin
      stall = (((taken_count / 30) % 4) == 1) ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(posedge clk);
      end while (!out_valid);
      taken_count++;
      if (taken_count == HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // --- directed literals ---
    // extreme bytes as delimiter and content, escaped e and %, good close
    lit_bytes = '{8'hFF, 8'h00, CH_BACKSLASH, 8'h65, CH_BACKSLASH, 8'h25, 8'hFF};
    send_literal();
    // backslash as delimiter: never an escape; doubled delimiter at the end
    lit_bytes = '{CH_BACKSLASH, CH_BACKSLASH, CH_BACKSLASH};
    send_literal();
    // missing closing delimiter
    lit_bytes = '{CH_QUOTE, 8'h78};
    send_literal();
    // delimiter followed by another byte, then a dropped byte
    lit_bytes = '{CH_QUOTE, CH_QUOTE, 8'h7A, 8'h71};
    send_literal();
    // trailing backslash
    lit_bytes = '{CH_DQUOTE, CH_BACKSLASH};
    send_literal();
    // literal of one byte
    lit_bytes = '{CH_QUOTE};
    send_literal();
    // escaped _ as the last byte: two bytes plus status from one request
    lit_bytes = '{CH_QUOTE, CH_BACKSLASH, 8'h5F};
    send_literal();

    // --- random literals ---
    while (sent_count < TARGET_BYTES) begin
      build_literal();
      send_literal();
    end
    in_valid <= 1'b0;

    // wait for the last expected result, then watch for stray ones
    do begin
      @(posedge clk);
    end while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("sql_string_literal_unescape test passed");
    else
      $display("sql_string_literal_unescape test failed");
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/sslu_pkg.sv
sv/sslu_front.sv
sv/sslu_queue.sv
sv/sslu_back.sv
sv/sql_string_literal_unescape.sv
tb/sslu_result_checker.sv
tb/tb_top.sv
